// File: src/interval_set_tracker_assert.svh
// assertion macros shared by the interval set tracker rtl
`ifndef INTERVAL_SET_TRACKER_ASSERT_SVH
`define INTERVAL_SET_TRACKER_ASSERT_SVH

// clocked check, held off while reset is asserted
`define ITV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition in one cycle implies another in the next cycle
`define ITV_ASSERT_NEXT(label, clk, rst_n, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
    else $error(msg);

`endif

// File: src/itv_pkg.sv
// package with constants and types of the interval set tracker
package itv_pkg;

  localparam int MAX_INTERVALS_DEF = 64;
  localparam int COORD_BITS_DEF    = 32;

  localparam int MODE_W  = 2;
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_EX2,
    ST_TAIL,
    ST_FIN
  } state_t;

endpackage

// File: src/itv_if.sv
// channel interfaces for the interval set tracker
interface itv_in_if;
  logic                         valid;
  logic                         ready;
  logic [itv_pkg::MODE_W-1:0]   mode;
  logic [itv_pkg::FIELD_W-1:0]  range_start;
  logic [itv_pkg::FIELD_W-1:0]  range_end;
  modport source (output valid, mode, range_start, range_end, input ready);
  modport sink (input valid, mode, range_start, range_end, output ready);
endinterface

interface itv_out_if;
  logic                         valid;
  logic                         ready;
  logic                         covered;
  logic                         status;
  logic [itv_pkg::COUNT_W-1:0]  interval_count;
  modport source (output valid, covered, status, interval_count, input ready);
  modport sink (input valid, covered, status, interval_count, output ready);
endinterface

// File: src/itv_ram.sv
// generic single write port ram with registered read
module itv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/interval_set_tracker.sv
// top level of the interval set tracker
// Keeps a sorted table of disjoint half-open intervals in two ram banks. An
// add or remove reads the live bank entry by entry, through one shared
// compare unit, and writes the new table into the other bank; if it fits,
// the banks swap at the end, else the table stays and status reports full.
// A query scans the live bank. Each stored interval takes a read state and
// a compare state, plus one extra write state when an add places the range
// ahead of a stored interval or a remove splits one (at most once per item),
// as the ram has a single read port and a single write port; a tail and a
// finish state close each add, remove or query, and a result held in the
// output register stretches the item until it is taken. Empty ranges and
// unused modes go straight to the finish state. The input is taken only
// while the sequencer is idle; a finished result waits in the output
// register while the next transfer is accepted. No clearing pass is needed
// after reset: entries beyond the count are never read.
`include "interval_set_tracker_assert.svh"

module interval_set_tracker #(
  parameter int MAX_INTERVALS = itv_pkg::MAX_INTERVALS_DEF,
  parameter int COORD_BITS    = itv_pkg::COORD_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  itv_in_if.sink    in_ch,
  itv_out_if.source out_ch
);
  localparam int ADDR_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
  localparam int NW     = $clog2(MAX_INTERVALS + 3);
  localparam int ENT_W  = 2 * COORD_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;

  itv_pkg::state_t state_r, state_nxt;
  logic [itv_pkg::MODE_W-1:0] mode_r, mode_nxt;
  coord_t s_r, s_nxt, e_r, e_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  coord_t pa_r, pa_nxt, pb_r, pb_nxt;
  logic placed_r, placed_nxt, cov_r, cov_nxt, full_r, full_nxt;
  logic sel_r, sel_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt, out_cov_r, out_cov_nxt, out_st_r, out_st_nxt;
  logic [itv_pkg::COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  // write port toward the spare bank
  logic   wr_en;
  coord_t wr_lo, wr_hi;
  logic   wr_ok;
  logic [ENT_W-1:0] rd0, rd1, rd;
  coord_t a, b, in_s, in_e;
  logic [NW-1:0] nf;
  logic last;
  logic tail_query, tail_full;

  assign in_s = coord_t'(in_ch.range_start);
  assign in_e = coord_t'(in_ch.range_end);
  assign rd   = sel_r ? rd1 : rd0;
  assign a    = rd[ENT_W-1:COORD_BITS];
  assign b    = rd[COORD_BITS-1:0];
  assign wr_ok = wr_en && (n_r < NW'(MAX_INTERVALS));
  assign last = ({1'b0, idx_r} + (CNT_W+1)'(1)) == {1'b0, cnt_r};

  itv_ram #(.WIDTH(ENT_W), .DEPTH(MAX_INTERVALS)) u_bank0 (
    .clk   (clk),
    .we    (wr_ok && sel_r),
    .waddr (n_r[ADDR_W-1:0]),
    .wdata ({wr_lo, wr_hi}),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (rd0)
  );

  itv_ram #(.WIDTH(ENT_W), .DEPTH(MAX_INTERVALS)) u_bank1 (
    .clk   (clk),
    .we    (wr_ok && !sel_r),
    .waddr (n_r[ADDR_W-1:0]),
    .wdata ({wr_lo, wr_hi}),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (rd1)
  );

  assign in_ch.ready           = (state_r == itv_pkg::ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.covered        = out_cov_r;
  assign out_ch.status         = out_st_r;
  assign out_ch.interval_count = out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itv_pkg::ST_IDLE;
      sel_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    pa_r      <= pa_nxt;
    pb_r      <= pb_nxt;
    placed_r  <= placed_nxt;
    cov_r     <= cov_nxt;
    full_r    <= full_nxt;
    n_r       <= n_nxt;
    idx_r     <= idx_nxt;
    out_cov_r <= out_cov_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;   mode_nxt = mode_r;
    s_nxt = s_r;           e_nxt = e_r;
    lo_nxt = lo_r;         hi_nxt = hi_r;
    pa_nxt = pa_r;         pb_nxt = pb_r;
    placed_nxt = placed_r; cov_nxt = cov_r; full_nxt = full_r;
    sel_nxt = sel_r;       n_nxt = n_r;
    idx_nxt = idx_r;       cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cov_nxt = out_cov_r; out_st_nxt = out_st_r; out_cnt_nxt = out_cnt_r;
    wr_en = 1'b0; wr_lo = lo_r; wr_hi = hi_r;
    nf = n_r;

    case (state_r)
      itv_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt = in_ch.mode;
          s_nxt = in_s;  e_nxt = in_e;
          lo_nxt = in_s; hi_nxt = in_e;
          placed_nxt = 1'b0; cov_nxt = 1'b0; full_nxt = 1'b0;
          n_nxt = '0; idx_nxt = '0;
          // empty range or unused mode: nothing to do
          if (in_e <= in_s || in_ch.mode == itv_pkg::MODE_UNUSED) begin
            mode_nxt = itv_pkg::MODE_QUERY;
            state_nxt = itv_pkg::ST_FIN;
          end else if (cnt_r == '0) begin
            state_nxt = itv_pkg::ST_TAIL;
          end else begin
            state_nxt = itv_pkg::ST_RD;
          end
        end
      end
      itv_pkg::ST_RD: begin
        // ram address is idx_r, data arrives next cycle
        state_nxt = itv_pkg::ST_EX;
      end
      itv_pkg::ST_EX: begin
        idx_nxt = idx_r + CNT_W'(1);
        state_nxt = last ? itv_pkg::ST_TAIL : itv_pkg::ST_RD;
        case (mode_r)
          itv_pkg::MODE_ADD: begin
            if (b < s_r) begin
              wr_en = 1'b1; wr_lo = a; wr_hi = b;
            end else if (a > e_r) begin
              wr_en = 1'b1;
              if (!placed_r) begin
                // merged range goes first, this interval follows
                placed_nxt = 1'b1;
                pa_nxt = a; pb_nxt = b;
                state_nxt = itv_pkg::ST_EX2;
              end else begin
                wr_lo = a; wr_hi = b;
              end
            end else begin
              if (a < lo_r) lo_nxt = a;
              if (b > hi_r) hi_nxt = b;
            end
          end
          itv_pkg::MODE_REMOVE: begin
            if (b <= s_r || a >= e_r) begin
              wr_en = 1'b1; wr_lo = a; wr_hi = b;
            end else if (a < s_r) begin
              wr_en = 1'b1; wr_lo = a; wr_hi = s_r;
              if (b > e_r) begin
                // split: right piece written next cycle
                pa_nxt = e_r; pb_nxt = b;
                state_nxt = itv_pkg::ST_EX2;
              end
            end else if (b > e_r) begin
              wr_en = 1'b1; wr_lo = e_r; wr_hi = b;
            end
          end
          default: begin
            if (a <= s_r && b >= e_r) cov_nxt = 1'b1;
          end
        endcase
        if (wr_en) n_nxt = n_r + NW'(1);
      end
      itv_pkg::ST_EX2: begin
        wr_en = 1'b1; wr_lo = pa_r; wr_hi = pb_r;
        n_nxt = n_r + NW'(1);
        state_nxt = (idx_r == cnt_r) ? itv_pkg::ST_TAIL : itv_pkg::ST_RD;
      end
      itv_pkg::ST_TAIL: begin
        if (mode_r == itv_pkg::MODE_ADD && !placed_r) begin
          wr_en = 1'b1;
          nf = n_r + NW'(1);
        end
        if (mode_r == itv_pkg::MODE_ADD || mode_r == itv_pkg::MODE_REMOVE) begin
          if (nf > NW'(MAX_INTERVALS)) begin
            full_nxt = 1'b1;
          end else begin
            sel_nxt = !sel_r;
            cnt_nxt = CNT_W'(nf);
          end
        end
        state_nxt = itv_pkg::ST_FIN;
      end
      itv_pkg::ST_FIN: begin
        // load the result once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cov_nxt = cov_r;
          out_st_nxt = full_r;
          out_cnt_nxt = itv_pkg::COUNT_W'(cnt_r);
          state_nxt = itv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itv_pkg::ST_IDLE;
    endcase
  end

  assign tail_query = (state_r == itv_pkg::ST_TAIL) && (mode_r == itv_pkg::MODE_QUERY);
  assign tail_full  = (state_r == itv_pkg::ST_TAIL) && (nf > NW'(MAX_INTERVALS));

  // stored count never exceeds table capacity
  `ITV_ASSERT(a_cnt_cap, clk, rst_n, cnt_r <= CNT_W'(MAX_INTERVALS), "count over capacity")
  // a query leaves the table alone
  `ITV_ASSERT_NEXT(a_query_keep, clk, rst_n, tail_query, $stable(sel_r) && $stable(cnt_r), "query changed table")
  // a full table keeps the live bank
  `ITV_ASSERT_NEXT(a_full_keep, clk, rst_n, tail_full, $stable(sel_r) && $stable(cnt_r), "full operation applied")
endmodule
